### hw/rtl/quoted_argument_tokenizer_macros.svh
`ifndef QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH

// concurrent check, masked while reset is high
`define QAT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("qat check failed");

// concurrent check that also holds through reset
`define QAT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("qat check failed");

`endif

### hw/rtl/qat_pkg.sv
`default_nettype none

package qat_pkg;

   localparam int MAX_RESULTS = 3;
   localparam int SLOT_W      = $clog2(MAX_RESULTS);

   localparam logic [7:0] CHAR_PIPE      = 8'h7c;
   localparam logic [7:0] CHAR_C         = 8'h63;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       is_final;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       ends_argument;
      logic       last_of_run;
   } rsp_type;

   // all results caused by one input byte
   typedef struct packed {
      logic [SLOT_W-1:0]            count;
      rsp_type [MAX_RESULTS-1:0]    slot;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } queue_port_type;

endpackage

`default_nettype wire

### hw/rtl/qat_queue.sv
`default_nettype none

module qat_queue
   import qat_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_port_type wr,
   output logic                full,
   input  wire logic           pop,
   output queue_port_type      rd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type    mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_wr, do_rd;

   assign full       = (count_ff == CW'(DEPTH));
   assign rd.valid   = (count_ff != '0);
   assign rd.bundle  = mem[rd_ptr_ff];
   assign do_wr      = wr.valid && !full;
   assign do_rd      = pop && rd.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CW'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr.bundle;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/qat_front.sv
`default_nettype none

module qat_front
   import qat_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output queue_port_type wr
);

   typedef enum logic [2:0] {
      MODE_BETWEEN = 3'd0,
      MODE_PIPE    = 3'd1,
      MODE_PLAIN   = 3'd2,
      MODE_QUOTED  = 3'd3,
      MODE_QESC    = 3'd4,
      MODE_LINK    = 3'd5,
      MODE_LINKP   = 3'd6
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic       quote_single_ff, quote_single_in;
   logic       accept;
   logic [7:0] chr;
   logic [7:0] quote_chr;
   bundle_type bun;

   function automatic bundle_type add_rsp(bundle_type b, logic [7:0] c, logic has,
                                          logic ends);
      bundle_type r;
      rsp_type    e;
      r                = b;
      e.out_byte       = has ? c : 8'd0;
      e.has_byte       = has;
      e.ends_argument  = ends;
      e.last_of_run    = 1'b0;
      r.slot[b.count]  = e;
      r.count          = b.count + SLOT_W'(1);
      return r;
   endfunction

   assign accept    = req_push && !queue_full;
   assign chr       = req_data.in_byte;
   assign quote_chr = quote_single_ff ? CHAR_SQUOTE : CHAR_DQUOTE;

   always_comb begin
      bun             = '0;
      mode_in         = mode_ff;
      quote_single_in = quote_single_ff;
      case (mode_ff)
         MODE_PIPE: begin
            bun = add_rsp(bun, CHAR_PIPE, 1'b1, 1'b0);
            if (chr == CHAR_C) begin
               bun     = add_rsp(bun, chr, 1'b1, 1'b0);
               mode_in = MODE_LINK;
            end else if (chr == CHAR_SPACE) begin
               bun     = add_rsp(bun, 8'd0, 1'b0, 1'b1);
               mode_in = MODE_BETWEEN;
            end else begin
               bun     = add_rsp(bun, chr, 1'b1, 1'b0);
               mode_in = MODE_PLAIN;
            end
         end
         MODE_PLAIN: begin
            if (chr == CHAR_SPACE) begin
               bun     = add_rsp(bun, 8'd0, 1'b0, 1'b1);
               mode_in = MODE_BETWEEN;
            end else begin
               bun     = add_rsp(bun, chr, 1'b1, 1'b0);
            end
         end
         MODE_QUOTED: begin
            if (chr == CHAR_BACKSLASH) begin
               mode_in = MODE_QESC;
            end else if (chr == quote_chr) begin
               bun     = add_rsp(bun, 8'd0, 1'b0, 1'b1);
               mode_in = MODE_BETWEEN;
            end else begin
               bun     = add_rsp(bun, chr, 1'b1, 1'b0);
            end
         end
         MODE_QESC: begin
            bun     = add_rsp(bun, chr, 1'b1, 1'b0);
            mode_in = MODE_QUOTED;
         end
         MODE_LINK: begin
            bun = add_rsp(bun, chr, 1'b1, 1'b0);
            if (chr == CHAR_PIPE) begin
               mode_in = MODE_LINKP;
            end
         end
         MODE_LINKP: begin
            bun = add_rsp(bun, chr, 1'b1, 1'b0);
            if (chr == CHAR_R) begin
               bun     = add_rsp(bun, 8'd0, 1'b0, 1'b1);
               mode_in = MODE_BETWEEN;
            end else if (chr != CHAR_PIPE) begin
               mode_in = MODE_LINK;
            end
         end
         default: begin
            mode_in = MODE_BETWEEN;
            if (chr == CHAR_SPACE) begin
               mode_in = MODE_BETWEEN;
            end else if (chr == CHAR_DQUOTE || chr == CHAR_SQUOTE) begin
               quote_single_in = (chr == CHAR_SQUOTE);
               mode_in         = MODE_QUOTED;
            end else if (chr == CHAR_PIPE) begin
               mode_in = MODE_PIPE;
            end else begin
               bun     = add_rsp(bun, chr, 1'b1, 1'b0);
               mode_in = MODE_PLAIN;
            end
         end
      endcase

      // end of line closes whatever is open
      if (req_data.is_final) begin
         if (mode_in == MODE_PIPE) begin
            bun = add_rsp(bun, CHAR_PIPE, 1'b1, 1'b0);
         end
         if (mode_in != MODE_BETWEEN) begin
            bun = add_rsp(bun, 8'd0, 1'b0, 1'b1);
         end
         mode_in = MODE_BETWEEN;
      end
   end

   assign wr.valid  = accept && (bun.count != '0);
   assign wr.bundle = bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_BETWEEN;
         quote_single_ff <= 1'b0;
      end else if (accept) begin
         mode_ff         <= mode_in;
         quote_single_ff <= quote_single_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/qat_back.sv
`default_nettype none

module qat_back
   import qat_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_port_type rd,
   output logic                queue_pop,
   output logic                rsp_empty,
   input  wire logic           rsp_pop,
   output rsp_type             rsp_data
);

   bundle_type        bun_ff, bun_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic              last;
   logic              advance;
   rsp_type           cur;

   assign cur     = bun_ff.slot[idx_ff];
   assign last    = (idx_ff == bun_ff.count - SLOT_W'(1));
   assign advance = valid_ff && rsp_pop;

   assign rsp_empty              = !valid_ff;
   assign rsp_data.out_byte      = cur.out_byte;
   assign rsp_data.has_byte      = cur.has_byte;
   assign rsp_data.ends_argument = cur.ends_argument;
   assign rsp_data.last_of_run   = last;

   always_comb begin
      bun_in    = bun_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      queue_pop = 1'b0;
      if (!valid_ff || (advance && last)) begin
         valid_in = rd.valid;
         if (rd.valid) begin
            bun_in    = rd.bundle;
            idx_in    = '0;
            queue_pop = 1'b1;
         end
      end else if (advance) begin
         idx_in = idx_ff + SLOT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      bun_ff <= bun_in;
   end

endmodule

`default_nettype wire

### hw/rtl/quoted_argument_tokenizer.sv
// a byte's results are written to the result queue, then loaded into the output bundle register
// throughput: one byte per cycle while req_full is low and each byte yields at most one result;
//   results leave at one per cycle while rsp_pop is high, a byte yields zero to three of them
// the result queue between parser and output holds DEPTH byte bundles
// reset (synchronous, active high) empties the queue and returns the parser
//   to between-arguments mode
`default_nettype none

module quoted_argument_tokenizer
   import qat_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_push,
   output logic         req_full,
   input  wire req_type req_data,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp_data
);

   queue_port_type q_wr;
   queue_port_type q_rd;
   logic           q_pop;

   qat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .queue_full (req_full),
      .wr         (q_wr)
   );

   qat_queue #(
      .DEPTH (DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .full  (req_full),
      .pop   (q_pop),
      .rd    (q_rd)
   );

   qat_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rd        (q_rd),
      .queue_pop (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### hw/rtl/qat_checker.sv
`default_nettype none
`include "quoted_argument_tokenizer_macros.svh"

module qat_checker
   import qat_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_push,
   input wire logic    req_full,
   input wire req_type req_data,
   input wire logic    rsp_empty,
   input wire logic    rsp_pop,
   input wire rsp_type rsp_data
);

   logic req_xfer;
   logic quiet;

   assign req_xfer = req_push && !req_full;
   // nothing waiting at the output and no input transfer
   assign quiet    = rsp_empty && !req_xfer;

   `QAT_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> rsp_empty)
   `QAT_ASSERT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
   `QAT_ASSERT(a_marker_alone, clock, reset, !rsp_empty |-> (rsp_data.has_byte != rsp_data.ends_argument))
   `QAT_ASSERT(a_no_stray_byte, clock, reset, !rsp_empty && !rsp_data.has_byte |-> rsp_data.out_byte == 8'd0)
   `QAT_ASSERT(a_no_result_from_nothing, clock, reset, quiet ##1 quiet |=> rsp_empty)

endmodule

bind quoted_argument_tokenizer qat_checker u_checker (.*);

`default_nettype wire
